>>> rtl/core/mm4_pkg.sv
package mm4_pkg;

  // Default matrix dimension
  localparam int DIM_DEF = 4;

  // Field widths
  localparam int IDX_W  = 4;
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;

  // Q16.16 fraction bits dropped after accumulation
  localparam int FRAC_W = 16;

  // Saturation limits
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

>>> rtl/core/mm4_lane.sv
// One multiplier lane: holds one column of the left matrix and one row of
// the right matrix, and forms one registered Q32.32 product per cycle.
module mm4_lane #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                                     clk,
  input  logic                                     wr_left,
  input  logic                                     wr_right,
  input  logic [$clog2(DIM)-1:0]                   wr_left_addr,
  input  logic [$clog2(DIM)-1:0]                   wr_right_addr,
  input  logic signed [mm4_pkg::DATA_W-1:0]        wr_left_data,
  input  logic signed [mm4_pkg::DATA_W-1:0]        wr_right_data,
  input  logic [$clog2(DIM)-1:0]                   rd_row,
  input  logic [$clog2(DIM)-1:0]                   rd_col,
  output logic signed [mm4_pkg::PROD_W-1:0]        prod
);

  logic signed [mm4_pkg::DATA_W-1:0] left_mem  [DIM];
  logic signed [mm4_pkg::DATA_W-1:0] right_mem [DIM];
  logic signed [mm4_pkg::PROD_W-1:0] prod_r;

  // Element storage, undefined until loaded
  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[wr_left_addr] <= wr_left_data;
    end
    if (wr_right) begin
      right_mem[wr_right_addr] <= wr_right_data;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    prod_r <= left_mem[rd_row] * right_mem[rd_col];
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/mm4_merge.sv
// Merging stage: registered adder tree over the lane products, then the
// arithmetic shift by the fraction width and saturation to 32 bits.
module mm4_merge #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic [$clog2(DIM*DIM)-1:0]             in_pos,
  input  logic signed [mm4_pkg::PROD_W-1:0]      prod [DIM],
  output logic                                   res_vld,
  output logic [$clog2(DIM*DIM)-1:0]             res_pos,
  output logic signed [mm4_pkg::DATA_W-1:0]      res_value
);

  localparam int LVLS = $clog2(DIM);
  localparam int NP   = 1 << LVLS;
  localparam int SW   = mm4_pkg::PROD_W + LVLS;
  localparam int HW   = SW - mm4_pkg::FRAC_W;
  localparam int PW   = $clog2(DIM*DIM);

  logic signed [SW-1:0] lane_ext [NP];
  logic signed [SW-1:0] tree_r   [LVLS][NP];
  logic                 vld_r    [LVLS];
  logic [PW-1:0]        pos_r    [LVLS];
  logic signed [HW-1:0] shf;
  logic                 ovf;
  logic signed [mm4_pkg::DATA_W-1:0] sat_nxt;
  logic signed [mm4_pkg::DATA_W-1:0] value_r;
  logic                 vld_out_r;
  logic [PW-1:0]        pos_out_r;

  // Sign-extend the lanes, pad the tree with zeros
  genvar n, l;
  generate
    for (n = 0; n < NP; n++) begin : g_ext
      if (n < DIM) begin : g_lane
        assign lane_ext[n] = {{LVLS{prod[n][mm4_pkg::PROD_W-1]}}, prod[n]};
      end else begin : g_pad
        assign lane_ext[n] = '0;
      end
    end

    // Registered pairwise adder tree
    for (l = 0; l < LVLS; l++) begin : g_lvl
      for (n = 0; n < (NP >> (l + 1)); n++) begin : g_node
        if (l == 0) begin : g_first
          always_ff @(posedge clk) begin
            tree_r[l][n] <= lane_ext[2*n] + lane_ext[2*n+1];
          end
        end else begin : g_next
          always_ff @(posedge clk) begin
            tree_r[l][n] <= tree_r[l-1][2*n] + tree_r[l-1][2*n+1];
          end
        end
      end

      // Tag pipeline alongside the tree
      if (l == 0) begin : g_tag0
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[l] <= 1'b0;
          end else begin
            vld_r[l] <= in_vld;
          end
          pos_r[l] <= in_pos;
        end
      end else begin : g_tagn
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[l] <= 1'b0;
          end else begin
            vld_r[l] <= vld_r[l-1];
          end
          pos_r[l] <= pos_r[l-1];
        end
      end
    end
  endgenerate

  // Floor shift and saturation
  always_comb begin
    shf = tree_r[LVLS-1][0][SW-1:mm4_pkg::FRAC_W];
    ovf = (shf[HW-1:mm4_pkg::DATA_W-1] != '0) && (shf[HW-1:mm4_pkg::DATA_W-1] != '1);
    if (ovf) begin
      sat_nxt = shf[HW-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX;
    end else begin
      sat_nxt = shf[mm4_pkg::DATA_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= vld_r[LVLS-1];
    end
    pos_out_r <= pos_r[LVLS-1];
    value_r   <= sat_nxt;
  end

  assign res_vld   = vld_out_r;
  assign res_pos   = pos_out_r;
  assign res_value = value_r;

endmodule

>>> rtl/core/matrix4_multiply.sv
// Output: the first product element leaves after the item with the last index
// is accepted, through the lane product, adder-tree and output registers, then
// one per cycle. Throughput: load items are taken one per cycle while busy is
// low; busy rises on the item with the last index and falls after the last
// result of the run, so no items are taken during a run. The receiver cannot stall.
// Reset (rst_n low, synchronous) clears control only; stored elements stay.
module matrix4_multiply #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mm4_pkg::IDX_W-1:0]             in_element_index,
  input  logic signed [mm4_pkg::DATA_W-1:0]     in_left_element,
  input  logic signed [mm4_pkg::DATA_W-1:0]     in_right_element,
  output logic                                  out_valid,
  output logic signed [mm4_pkg::DATA_W-1:0]     out_product_element,
  output logic [mm4_pkg::IDX_W-1:0]             out_product_index,
  output logic                                  out_last_of_run
);

  localparam int CELLS = DIM * DIM;
  localparam int DW    = $clog2(DIM);
  localparam int PW    = $clog2(CELLS);
  localparam int IW    = mm4_pkg::IDX_W;

  logic          accept;
  logic          in_range;
  logic          wr_en;
  logic          trigger;
  logic [DW-1:0] idx_col;
  logic [DW-1:0] idx_row;

  logic          busy_r, busy_nxt;
  logic          run_r, run_nxt;
  logic [DW-1:0] row_r, row_nxt;
  logic [DW-1:0] col_r, col_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          iss_vld_r;
  logic [PW-1:0] iss_pos_r;

  logic signed [mm4_pkg::PROD_W-1:0] prod [DIM];
  logic                              res_vld;
  logic [PW-1:0]                     res_pos;
  logic signed [mm4_pkg::DATA_W-1:0] res_value;

  // Item decode: column and row of the carried index
  always_comb begin
    accept   = start && !busy_r;
    in_range = 32'(in_element_index) < CELLS;
    wr_en    = accept && in_range;
    trigger  = wr_en && (32'(in_element_index) == CELLS - 1);
    idx_col  = '0;
    for (int c = 1; c < DIM; c++) begin
      if (32'(in_element_index) >= c * DIM) begin
        idx_col = DW'(c);
      end
    end
    idx_row = DW'(32'(in_element_index) - 32'(idx_col) * DIM);
  end

  // Lanes: lane k holds left column k and right row k
  genvar k;
  generate
    for (k = 0; k < DIM; k++) begin : g_lane
      mm4_lane #(.DIM(DIM)) u_lane (
        .clk           (clk),
        .wr_left       (wr_en && (idx_col == DW'(k))),
        .wr_right      (wr_en && (idx_row == DW'(k))),
        .wr_left_addr  (idx_row),
        .wr_right_addr (idx_col),
        .wr_left_data  (in_left_element),
        .wr_right_data (in_right_element),
        .rd_row        (row_r),
        .rd_col        (col_r),
        .prod          (prod[k])
      );
    end
  endgenerate

  // Run sequencer: walks the product in column-major order
  always_comb begin
    run_nxt  = run_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    if (trigger) begin
      run_nxt  = 1'b1;
      busy_nxt = 1'b1;
      row_nxt  = '0;
      col_nxt  = '0;
      pos_nxt  = '0;
    end else if (run_r) begin
      pos_nxt = pos_r + 1'b1;
      if (row_r == DW'(DIM - 1)) begin
        row_nxt = '0;
        col_nxt = col_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
      if (pos_r == PW'(CELLS - 1)) begin
        run_nxt = 1'b0;
      end
    end
    if (res_vld && (res_pos == PW'(CELLS - 1))) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      run_r     <= 1'b0;
      iss_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      run_r     <= run_nxt;
      iss_vld_r <= run_r;
    end
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    pos_r     <= pos_nxt;
    iss_pos_r <= pos_r;
  end

  // Merge the lane products
  mm4_merge #(.DIM(DIM)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (iss_vld_r),
    .in_pos    (iss_pos_r),
    .prod      (prod),
    .res_vld   (res_vld),
    .res_pos   (res_pos),
    .res_value (res_value)
  );

  assign busy                = busy_r;
  assign out_valid           = res_vld;
  assign out_product_element = res_value;
  assign out_product_index   = IW'(res_pos);
  assign out_last_of_run     = res_pos == PW'(CELLS - 1);

endmodule

>>> rtl/core/mm4_checker.sv
// Port-level checks on the multiplier's run behavior
module mm4_checker #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [mm4_pkg::IDX_W-1:0]     in_element_index,
  input logic                          out_valid,
  input logic [mm4_pkg::IDX_W-1:0]     out_product_index,
  input logic                          out_last_of_run
);

  localparam int CELLS = DIM * DIM;
  localparam int IW    = mm4_pkg::IDX_W;

  // A trigger item starts a run
  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (32'(in_element_index) == CELLS - 1)) |=> busy)
    else $error("trigger item did not raise busy");

  // Results only come out during a run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a run");

  // A run is one unbroken stream
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> out_valid)
    else $error("gap inside a result run");

  // Indices step by one within a run
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=>
      (out_product_index == IW'($past(out_product_index) + 1'b1)))
    else $error("product index did not advance by one");

  // The last element ends the run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !busy)
    else $error("busy held after last result");

endmodule

bind matrix4_multiply mm4_checker #(.DIM(DIM)) u_mm4_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_element_index  (in_element_index),
  .out_valid         (out_valid),
  .out_product_index (out_product_index),
  .out_last_of_run   (out_last_of_run)
);
